// File: rtl/arns_pkg.sv
// Package for the arpeggio and random drift note scheduler.
// Holds widths, codes, controller/datapath types and the arpeggio offset table.
// No dependencies; every other file imports it.
`default_nettype none

package arns_pkg;

	localparam int N_W     = 5;
	localparam int BPM_W   = 10;
	localparam int NOTE_W  = 15;
	localparam int SR_W    = 18;
	localparam int KNOB_W  = 16;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W   = 18;
	localparam int CNT_W   = 21;
	localparam int SEED_W  = 32;
	localparam int DVD_W   = 24;
	localparam int DEN_W   = 13;
	localparam int MUL_W   = 25;
	localparam int DIV_CNT_W = 5;

	localparam int BLOCK_MAX_DEF = 24;

	localparam logic [MODE_W-1:0] MODE_EXT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DRIFT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_SPEED   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_AMOUNT  = 2'd3;

	localparam logic [SR_W-1:0]   SR_RESET     = 18'd48000;
	localparam logic [KNOB_W-1:0] AMOUNT_RESET = 16'd19661;
	localparam logic [SEED_W-1:0] SEED_RESET   = 32'h00C0FFEE;
	localparam logic [SEED_W-1:0] LCG_MUL      = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD      = 32'd1013904223;

	localparam logic [KNOB_W-1:0] ARP_SPEED_MIN = 16'd3277;
	localparam logic [27:0] DIV_STEP_1 = 28'd65536000;
	localparam logic [27:0] DIV_STEP_2 = 28'd131072000;
	localparam logic [27:0] DIV_STEP_3 = 28'd196608000;
	localparam logic [11:0] DIV_KNOB_MUL = 12'd3999;
	localparam logic [BPM_W-1:0] BPM_MIN = 10'd20;
	localparam logic [BPM_W-1:0] BPM_DEFAULT = 10'd120;
	localparam logic [CNT_W-1:0] CNT_MAX = 21'h1FFFFF;
	localparam logic [NOTE_W-1:0] NOTE_MAX = 15'h7FFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LCG1,
		ST_MUL_FS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_LCG2,
		ST_MUL_AMT,
		ST_NOTE_D,
		ST_DIV,
		ST_NOTE_A,
		ST_PUBLISH
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECIDE,
		OP_LCG1,
		OP_MUL_FS,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_LCG2,
		OP_MUL_AMT,
		OP_NOTE_D,
		OP_DIV_STEP,
		OP_NOTE_A,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic mode_drift;
		logic mode_arp;
		logic speed_ok;
		logic drift_hit;
		logic arp_hit;
		logic div_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [3:0] arp_offset(input logic [1:0] step);
		logic [3:0] v;
		unique case (step)
			2'd0: v = 4'd0;
			2'd1: v = 4'd4;
			2'd2: v = 4'd7;
			2'd3: v = 4'd12;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/arns_tick_if.sv
// Input channel of the note scheduler: one block tick per word.
// Depends on arns_pkg for field widths.
`default_nettype none

interface arns_tick_if;
	import arns_pkg::*;

	logic              valid;
	logic              ready;
	logic [N_W-1:0]    elapsed_samples;
	logic [BPM_W-1:0]  tempo_bpm;
	logic [NOTE_W-1:0] base_pitch;

	modport source(output valid, elapsed_samples, tempo_bpm, base_pitch, input ready);
	modport sink(input valid, elapsed_samples, tempo_bpm, base_pitch, output ready);
endinterface

`default_nettype wire

// File: rtl/arns_note_if.sv
// Output channel of the note scheduler: one trigger result per word.
// Depends on arns_pkg for field widths.
`default_nettype none

interface arns_note_if;
	import arns_pkg::*;

	logic              valid;
	logic              ready;
	logic              fire;
	logic [NOTE_W-1:0] note_out;

	modport source(output valid, fire, note_out, input ready);
	modport sink(input valid, fire, note_out, output ready);
endinterface

`default_nettype wire

// File: rtl/arns_ctrl.sv
// Controller of the note scheduler: sequences datapath operations per tick.
// Depends on arns_pkg for state, operation and status types.
`default_nettype none

module arns_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tick_valid,
	output logic                     tick_ready,
	input  wire arns_pkg::dp_status_t status,
	output arns_pkg::dp_op_t         op
);
	import arns_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		op         = OP_NONE;
		tick_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tick_ready = 1'b1;
				if (tick_valid) begin
					op      = OP_LOAD;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				op = OP_DECIDE;
				priority if (status.mode_drift && status.drift_hit) begin
					state_d = ST_LCG1;
				end else if (status.mode_arp && status.speed_ok && status.arp_hit) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_PUBLISH;
				end
			end
			ST_LCG1: begin
				op      = OP_LCG1;
				state_d = ST_MUL_FS;
			end
			ST_MUL_FS: begin
				op      = OP_MUL_FS;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				op      = OP_MUL_LO;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				op      = OP_MUL_HI;
				state_d = ST_LCG2;
			end
			ST_LCG2: begin
				op      = OP_LCG2;
				state_d = ST_MUL_AMT;
			end
			ST_MUL_AMT: begin
				op      = OP_MUL_AMT;
				state_d = ST_NOTE_D;
			end
			ST_NOTE_D: begin
				op      = OP_NOTE_D;
				state_d = ST_PUBLISH;
			end
			ST_DIV: begin
				op = OP_DIV_STEP;
				if (status.div_last) begin
					state_d = ST_NOTE_A;
				end
			end
			ST_NOTE_A: begin
				op      = OP_NOTE_A;
				state_d = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (status.out_free) begin
					op      = OP_PUBLISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/arns_dp.sv
// Datapath of the note scheduler: configuration, timers, LCG, shared multiplier,
// radix-2 divider and output register. Depends on arns_pkg; driven by arns_ctrl.
`default_nettype none

module arns_dp #(
	parameter int BLOCK_MAX = arns_pkg::BLOCK_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [arns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [arns_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [arns_pkg::N_W-1:0]       elapsed_samples,
	input  wire logic [arns_pkg::BPM_W-1:0]     tempo_bpm,
	input  wire logic [arns_pkg::NOTE_W-1:0]    base_pitch,
	input  wire arns_pkg::dp_op_t               op,
	output arns_pkg::dp_status_t                status,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                out_fire,
	output logic [arns_pkg::NOTE_W-1:0]         out_note
);
	import arns_pkg::*;

	localparam int N_CAP_I = (BLOCK_MAX < (1 << N_W)) ? BLOCK_MAX : (1 << N_W) - 1;
	localparam logic [N_W-1:0] N_CAP = N_W'(N_CAP_I);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

	logic [MODE_W-1:0] play_mode_q;
	logic [SR_W-1:0]   sample_rate_q;
	logic [KNOB_W-1:0] mod_speed_q;
	logic [KNOB_W-1:0] mod_amount_q;

	logic [CNT_W-1:0]  drift_cnt_q;
	logic [CNT_W-1:0]  arp_cnt_q;
	logic [1:0]        arp_step_q;
	logic [SEED_W-1:0] seed_q;

	logic [N_W-1:0]    n_q;
	logic [BPM_W-1:0]  bpm_q;
	logic [NOTE_W-1:0] base_q;

	logic [33:0]       ivl_q;
	logic [MUL_W-1:0]  acc_q;
	logic [41:0]       prod_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic              res_fire_q;
	logic [NOTE_W-1:0] res_note_q;
	logic              out_valid_q;
	logic              out_fire_q;
	logic [NOTE_W-1:0] out_note_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q   <= MODE_ARP;
			sample_rate_q <= SR_RESET;
			mod_speed_q   <= '0;
			mod_amount_q  <= AMOUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLAY_MODE:   play_mode_q   <= cfg_data[MODE_W-1:0];
				CFG_SAMPLE_RATE: sample_rate_q <= cfg_data[SR_W-1:0];
				CFG_MOD_SPEED:   mod_speed_q   <= cfg_data[KNOB_W-1:0];
				CFG_MOD_AMOUNT:  mod_amount_q  <= cfg_data[KNOB_W-1:0];
				default: ;
			endcase
		end
	end

	logic [N_W-1:0]    n_clamp;
	logic [SEED_W-1:0] seed_next;
	logic [16:0]       f_knob;
	logic [23:0]       r_draw;
	logic              off_neg;
	logic [MUL_W-1:0]  abs_diff;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic [42:0]       drift_sum;
	logic [42:0]       mag3;
	logic [13:0]       off_mag;
	logic signed [16:0] drift_note;
	logic [NOTE_W-1:0] drift_sat;
	logic [27:0]       speed_scaled;
	logic [1:0]        div_sel;
	logic [BPM_W-1:0]  bpm_eff;
	logic [DEN_W-1:0]  den_next;
	logic [DVD_W-1:0]  dvd_init;
	logic [DEN_W:0]    trial;
	logic              q_bit;
	logic [DEN_W-1:0]  rem_next;
	logic [NOTE_W:0]   arp_note;
	logic [NOTE_W-1:0] arp_sat;

	assign n_clamp   = (elapsed_samples > N_CAP) ? N_CAP : elapsed_samples;
	assign seed_next = seed_q * LCG_MUL + LCG_ADD;
	assign f_knob    = 17'd1966 + ((17'h10000 - {1'b0, mod_speed_q}) >> 1);
	assign r_draw    = seed_q[31:8];
	assign off_neg   = ~r_draw[23];
	assign abs_diff  = off_neg ? (25'h1000000 - {r_draw, 1'b0})
	                           : {1'b0, r_draw[22:0], 1'b0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_MUL_FS: begin
				mul_a = MUL_W'(f_knob);
				mul_b = MUL_W'(sample_rate_q);
			end
			OP_MUL_LO: begin
				mul_a = MUL_W'(ivl_q[16:0]);
				mul_b = {1'b0, 24'h800000} + {1'b0, r_draw};
			end
			OP_MUL_HI: begin
				mul_a = MUL_W'(ivl_q[33:17]);
				mul_b = {1'b0, 24'h800000} + {1'b0, r_draw};
			end
			OP_MUL_AMT: begin
				mul_a = abs_diff;
				mul_b = MUL_W'(mod_amount_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign drift_sum  = {1'b0, prod_q} + 43'(acc_q);
	assign mag3       = {2'b0, prod_q[40:0]} + {1'b0, prod_q[40:0], 1'b0};
	assign off_mag    = mag3[42:29];
	assign drift_note = off_neg ? ($signed({2'b0, base_q}) - $signed({3'b0, off_mag}))
	                            : ($signed({2'b0, base_q}) + $signed({3'b0, off_mag}));
	always_comb begin
		priority if (drift_note[16]) begin
			drift_sat = '0;
		end else if (drift_note[15]) begin
			drift_sat = NOTE_MAX;
		end else begin
			drift_sat = drift_note[14:0];
		end
	end

	assign speed_scaled = 28'(mod_speed_q) * 28'(DIV_KNOB_MUL);
	always_comb begin
		priority if (speed_scaled >= DIV_STEP_3) begin
			div_sel = 2'd3;
		end else if (speed_scaled >= DIV_STEP_2) begin
			div_sel = 2'd2;
		end else if (speed_scaled >= DIV_STEP_1) begin
			div_sel = 2'd1;
		end else begin
			div_sel = 2'd0;
		end
	end
	assign bpm_eff  = (bpm_q < BPM_MIN) ? BPM_DEFAULT : bpm_q;
	assign den_next = DEN_W'(bpm_eff) << div_sel;
	assign dvd_init = {sample_rate_q, 6'b0} - {4'b0, sample_rate_q, 2'b0};

	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign q_bit    = trial >= {1'b0, den_q};
	assign rem_next = q_bit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	assign arp_note = {1'b0, base_q} + {4'b0, arp_offset(arp_step_q), 8'b0};
	assign arp_sat  = arp_note[NOTE_W] ? NOTE_MAX : arp_note[NOTE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_cnt_q <= '0;
			arp_cnt_q   <= '0;
			arp_step_q  <= '0;
			seed_q      <= SEED_RESET;
			div_cnt_q   <= '0;
		end else begin
			unique case (op)
				OP_DECIDE: begin
					if (status.mode_drift && !status.drift_hit) begin
						drift_cnt_q <= drift_cnt_q - CNT_W'(n_q);
					end
					if (status.mode_arp && status.speed_ok && !status.arp_hit) begin
						arp_cnt_q <= arp_cnt_q - CNT_W'(n_q);
					end
					div_cnt_q <= '0;
				end
				OP_LCG1: seed_q <= seed_next;
				OP_LCG2: begin
					seed_q      <= seed_next;
					drift_cnt_q <= CNT_W'(drift_sum[42:23]);
				end
				OP_DIV_STEP: div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				OP_NOTE_A: begin
					arp_cnt_q  <= (dvd_q > DVD_W'(CNT_MAX)) ? CNT_MAX : dvd_q[CNT_W-1:0];
					arp_step_q <= arp_step_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				n_q    <= n_clamp;
				bpm_q  <= tempo_bpm;
				base_q <= base_pitch;
			end
			OP_DECIDE: begin
				res_fire_q <= 1'b0;
				res_note_q <= '0;
				dvd_q      <= dvd_init;
				den_q      <= den_next;
				rem_q      <= '0;
			end
			OP_MUL_FS:  ivl_q  <= mul_p[33:0];
			OP_MUL_LO:  acc_q  <= mul_p[41:17];
			OP_MUL_HI:  prod_q <= mul_p[41:0];
			OP_MUL_AMT: prod_q <= mul_p[41:0];
			OP_NOTE_D: begin
				res_fire_q <= 1'b1;
				res_note_q <= drift_sat;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			end
			OP_NOTE_A: begin
				res_fire_q <= 1'b1;
				res_note_q <= arp_sat;
			end
			OP_PUBLISH: begin
				out_fire_q <= res_fire_q;
				out_note_q <= res_note_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.mode_drift = play_mode_q == MODE_DRIFT;
	assign status.mode_arp   = play_mode_q == MODE_ARP;
	assign status.speed_ok   = mod_speed_q >= ARP_SPEED_MIN;
	assign status.drift_hit  = drift_cnt_q <= CNT_W'(n_q);
	assign status.arp_hit    = arp_cnt_q <= CNT_W'(n_q);
	assign status.div_last   = div_cnt_q == DIV_LAST;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_fire  = out_fire_q;
	assign out_note  = out_note_q;

endmodule

`default_nettype wire

// File: rtl/arp_and_random_note_scheduler_core.sv
// Top level of the arpeggio and random drift note scheduler.
// Depends on arns_pkg, arns_tick_if, arns_note_if, arns_ctrl and arns_dp.
//
//   port       dir   word / handshake
//   tick       in    elapsed_samples, tempo_bpm, base_pitch; valid/ready
//   result     out   fire, note_out; valid/ready
//   cfg_*      in    cfg_we, cfg_index, cfg_data; write on cfg_we
//
// A tick that does not fire goes from DECIDE to PUBLISH. A drift trigger uses the
// shared 25x25 multiplier in four steps beside two LCG steps, then NOTE_D; an
// arpeggio trigger runs the one-bit-per-cycle divider over 24 quotient bits, then
// NOTE_A. One tick is in work at a time; the result register holds a word while
// the next tick is taken. Reset is asynchronous; it restores config, timers and seed.
`default_nettype none

module arp_and_random_note_scheduler_core #(
	parameter int BLOCK_MAX = arns_pkg::BLOCK_MAX_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [arns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [arns_pkg::CFG_W-1:0]     cfg_data,
	arns_tick_if.sink                           tick,
	arns_note_if.source                         result
);
	import arns_pkg::*;

	dp_op_t     op;
	dp_status_t status;
	logic       tick_ready;

	arns_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick_ready),
		.status     (status),
		.op         (op)
	);

	arns_dp #(
		.BLOCK_MAX (BLOCK_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.elapsed_samples (tick.elapsed_samples),
		.tempo_bpm       (tick.tempo_bpm),
		.base_pitch      (tick.base_pitch),
		.op              (op),
		.status          (status),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_fire        (result.fire),
		.out_note        (result.note_out)
	);

	assign tick.ready = tick_ready;

endmodule

`default_nettype wire
